FILE: rtl/sncf_pkg.sv
// ----------------------------------------------------------------------------
// sncf_pkg: shared types and codes of the SPI NOR flash command engine
// Item structs, queue entry and push bundles, opcode, operation, result kind
// and flash command codes, sequencer phases.
// ----------------------------------------------------------------------------
package sncf_pkg;

  // Flash address width (fixed 24-bit addressing)
  localparam int unsigned ADDR_BITS = 24;
  localparam int unsigned LEN_BITS  = 24;

  // Input opcodes
  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_HOST  = 2'd1;
  localparam logic [1:0] OPC_REPLY = 2'd2;

  // Operations selected by a start request
  localparam logic [2:0] OP_WREN    = 3'd0;
  localparam logic [2:0] OP_ERASE   = 3'd1;
  localparam logic [2:0] OP_PROGRAM = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_CRC     = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_SPI    = 2'd0;
  localparam logic [1:0] KIND_HOST   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Flash command bytes
  localparam logic [7:0] SPI_WREN  = 8'h06;
  localparam logic [7:0] SPI_RDSR  = 8'h05;
  localparam logic [7:0] SPI_SE    = 8'h20;
  localparam logic [7:0] SPI_PP    = 8'h02;
  localparam logic [7:0] SPI_READ  = 8'h03;
  localparam logic [7:0] SPI_DUMMY = 8'hFF;

  // CRC-32 (reflected) and poll limit reset
  localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
  localparam logic [31:0] POLL_LIMIT_RST = 32'd10000000;

  // Register byte addresses
  localparam logic [2:0] REG_POLL_LIMIT = 3'd0;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [2:0]           operation;
    logic [ADDR_BITS-1:0] flash_address;
    logic [LEN_BITS-1:0]  transfer_length;
    logic [7:0]           host_byte;
    logic [7:0]           flash_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  spi_byte;
    logic        release_select;
    logic [7:0]  host_data;
    logic [31:0] crc_value;
    logic        success;
    logic        last;
  } out_item_t;

  // Request class decided by the front end
  typedef enum logic [1:0] {
    CMD_START,
    CMD_HOST,
    CMD_REPLY,
    CMD_NONE
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WE_REPLY,
    PH_CMD_REPLY,
    PH_ADDR_REPLY,
    PH_WAIT_HOST,
    PH_DATA_REPLY,
    PH_POLL_CMD,
    PH_POLL_STAT
  } phase_e;

  // Classified request held in the front queue
  typedef struct packed {
    cmd_e                 cls;
    logic [2:0]           operation;
    logic [ADDR_BITS-1:0] flash_address;
    logic [LEN_BITS-1:0]  transfer_length;
    logic [7:0]           data;
  } req_t;

  // Results pushed by the sequencer in one cycle (zero, one or two)
  typedef struct packed {
    logic [1:0] num;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

endpackage

FILE: rtl/sncf_front.sv
// ----------------------------------------------------------------------------
// sncf_front: request intake and classification
// Decodes the opcode of each incoming request, drops unused opcodes and keeps
// the rest in a two-entry queue ahead of the sequencer.
// ----------------------------------------------------------------------------
module sncf_front
  import sncf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     req_valid_o,
  output req_t     req_o,
  input  logic     req_pop_i
);

  req_t       q_mem [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  req_t       req_new;
  logic       push;

  // Classify the incoming request
  always_comb begin
    req_new                 = '0;
    req_new.operation       = in_item_i.operation;
    req_new.flash_address   = in_item_i.flash_address;
    req_new.transfer_length = in_item_i.transfer_length;
    unique case (in_item_i.opcode)
      OPC_START: begin
        req_new.cls = CMD_START;
      end
      OPC_HOST: begin
        req_new.cls  = CMD_HOST;
        req_new.data = in_item_i.host_byte;
      end
      OPC_REPLY: begin
        req_new.cls  = CMD_REPLY;
        req_new.data = in_item_i.flash_byte;
      end
      default: begin
        req_new.cls = CMD_NONE;
      end
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o && (req_new.cls != CMD_NONE);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = q_mem[rd_q];

  // Advance pointers and fill level
  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = req_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, req_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the classified request
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= req_new;
    end
  end

endmodule

FILE: rtl/sncf_seq.sv
// ----------------------------------------------------------------------------
// sncf_seq: flash command sequencer
// Takes one classified request a cycle while the result queue has room, steps
// the phase and yields send, read and finish results, up to two per request.
// ----------------------------------------------------------------------------
module sncf_seq
  import sncf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] poll_limit_i,
  input  logic        req_valid_i,
  input  req_t        req_i,
  output logic        req_pop_o,
  input  logic        out_space_i,
  output push_t       push_o
);

  phase_e               phase_q, phase_d;
  logic [2:0]           op_q, op_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [LEN_BITS-1:0]  rem_q, rem_d;
  logic [1:0]           idx_q, idx_d;
  logic [31:0]          crc_q, crc_d;
  logic [31:0]          poll_q, poll_d;

  logic                 take;
  logic [LEN_BITS-1:0]  rem_dec;
  logic [31:0]          crc_fold;
  logic [31:0]          crc_src;
  logic [31:0]          poll_inc;
  out_item_t            nd_res;
  phase_e               nd_phase;
  logic [LEN_BITS-1:0]  nd_rem;
  out_item_t            bp_res;
  phase_e               bp_phase;
  logic [1:0]           sa_idx;
  logic [7:0]           sa_byte;
  logic                 sa_rel;
  out_item_t            res0, res1;
  logic [1:0]           nres;

  function automatic out_item_t mk_send(logic [7:0] b, logic rel);
    out_item_t r;
    r                = '0;
    r.kind           = KIND_SPI;
    r.spi_byte       = b;
    r.release_select = rel;
    return r;
  endfunction

  function automatic out_item_t mk_finish(logic [31:0] crc, logic ok);
    out_item_t r;
    r           = '0;
    r.kind      = KIND_FINISH;
    r.crc_value = crc;
    r.success   = ok;
    return r;
  endfunction

  function automatic out_item_t mk_host(logic [7:0] b);
    out_item_t r;
    r           = '0;
    r.kind      = KIND_HOST;
    r.host_data = b;
    return r;
  endfunction

  // Fold one byte into the reflected CRC, bit by bit
  function automatic logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
    end
    return x;
  endfunction

  assign take      = req_valid_i && out_space_i;
  assign req_pop_o = take;

  // Shared helpers: next data byte, start of polling, address byte
  always_comb begin
    rem_dec  = rem_q - LEN_BITS'(1);
    crc_fold = fold_byte(crc_q, req_i.data);
    poll_inc = poll_q + 32'd1;
    crc_src  = (phase_q == PH_DATA_REPLY && op_q == OP_CRC) ? crc_fold : crc_q;

    if (rem_q == '0) begin
      nd_res   = mk_finish((op_q == OP_CRC) ? ~crc_src : 32'd0, 1'b1);
      nd_phase = PH_IDLE;
      nd_rem   = rem_q;
    end else begin
      nd_res   = mk_send(SPI_DUMMY, rem_q == LEN_BITS'(1));
      nd_phase = PH_DATA_REPLY;
      nd_rem   = rem_dec;
    end

    if (poll_limit_i == 32'd0) begin
      bp_res   = mk_finish(32'd0, 1'b0);
      bp_phase = PH_IDLE;
    end else begin
      bp_res   = mk_send(SPI_RDSR, 1'b0);
      bp_phase = PH_POLL_CMD;
    end

    sa_idx = (phase_q == PH_ADDR_REPLY) ? idx_q + 2'd1 : 2'd0;
    unique case (sa_idx)
      2'd0:    sa_byte = addr_q[ADDR_BITS-1 -: 8];
      2'd1:    sa_byte = addr_q[ADDR_BITS-9 -: 8];
      default: sa_byte = addr_q[7:0];
    endcase
    sa_rel = (sa_idx == 2'd2) && (op_q == OP_ERASE || rem_q == '0);
  end

  // Next phase, state and results
  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    addr_d  = addr_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    crc_d   = crc_q;
    poll_d  = poll_q;
    res0    = '0;
    res1    = '0;
    nres    = 2'd0;

    if (take) begin
      unique case (req_i.cls)
        CMD_START: begin
          if (phase_q == PH_IDLE) begin
            nres = 2'd1;
            if (req_i.operation > OP_CRC) begin
              res0 = mk_finish(32'd0, 1'b0);
            end else begin
              op_d   = req_i.operation;
              addr_d = req_i.flash_address;
              rem_d  = req_i.transfer_length;
              idx_d  = 2'd0;
              poll_d = 32'd0;
              crc_d  = CRC_INIT;
              if (req_i.operation <= OP_PROGRAM) begin
                phase_d = PH_WE_REPLY;
                res0    = mk_send(SPI_WREN, 1'b1);
              end else begin
                phase_d = PH_CMD_REPLY;
                res0    = mk_send(SPI_READ, 1'b0);
              end
            end
          end
        end
        CMD_HOST: begin
          if (phase_q == PH_WAIT_HOST) begin
            phase_d = PH_DATA_REPLY;
            res0    = mk_send(req_i.data, rem_q == LEN_BITS'(1));
            rem_d   = rem_dec;
            nres    = 2'd1;
          end
        end
        CMD_REPLY: begin
          unique case (phase_q)
            PH_WE_REPLY: begin
              nres = 2'd1;
              if (op_q == OP_WREN) begin
                phase_d = PH_IDLE;
                res0    = mk_finish(32'd0, 1'b1);
              end else begin
                phase_d = PH_CMD_REPLY;
                res0    = mk_send((op_q == OP_ERASE) ? SPI_SE : SPI_PP, 1'b0);
              end
            end
            PH_CMD_REPLY: begin
              phase_d = PH_ADDR_REPLY;
              idx_d   = sa_idx;
              res0    = mk_send(sa_byte, sa_rel);
              nres    = 2'd1;
            end
            PH_ADDR_REPLY: begin
              if (idx_q < 2'd2) begin
                idx_d = sa_idx;
                res0  = mk_send(sa_byte, sa_rel);
                nres  = 2'd1;
              end else if (op_q == OP_ERASE ||
                           (op_q == OP_PROGRAM && rem_q == '0)) begin
                phase_d = bp_phase;
                poll_d  = 32'd0;
                res0    = bp_res;
                nres    = 2'd1;
              end else if (op_q == OP_PROGRAM) begin
                phase_d = PH_WAIT_HOST;
              end else begin
                phase_d = nd_phase;
                rem_d   = nd_rem;
                res0    = nd_res;
                nres    = 2'd1;
              end
            end
            PH_DATA_REPLY: begin
              if (op_q == OP_PROGRAM) begin
                if (rem_q == '0) begin
                  phase_d = bp_phase;
                  poll_d  = 32'd0;
                  res0    = bp_res;
                  nres    = 2'd1;
                end else begin
                  phase_d = PH_WAIT_HOST;
                end
              end else if (op_q == OP_READ) begin
                phase_d = nd_phase;
                rem_d   = nd_rem;
                res0    = mk_host(req_i.data);
                res1    = nd_res;
                nres    = 2'd2;
              end else begin
                crc_d   = crc_fold;
                phase_d = nd_phase;
                rem_d   = nd_rem;
                res0    = nd_res;
                nres    = 2'd1;
              end
            end
            PH_POLL_CMD: begin
              phase_d = PH_POLL_STAT;
              res0    = mk_send(SPI_DUMMY, 1'b1);
              nres    = 2'd1;
            end
            PH_POLL_STAT: begin
              nres = 2'd1;
              // status bit 0 is the busy flag
              if (!req_i.data[0]) begin
                phase_d = PH_IDLE;
                res0    = mk_finish(32'd0, 1'b1);
              end else begin
                poll_d = poll_inc;
                if (poll_inc >= poll_limit_i) begin
                  phase_d = PH_IDLE;
                  res0    = mk_finish(32'd0, 1'b0);
                end else begin
                  phase_d = PH_POLL_CMD;
                  res0    = mk_send(SPI_RDSR, 1'b0);
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    // Mark the final result of this request
    if (nres == 2'd1) begin
      res0.last = 1'b1;
    end
    if (nres == 2'd2) begin
      res1.last = 1'b1;
    end

    push_o.num = nres;
    push_o.r0  = res0;
    push_o.r1  = res1;
  end

  // Phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Operation context
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q   <= OP_WREN;
      addr_q <= '0;
      rem_q  <= '0;
      idx_q  <= 2'd0;
      crc_q  <= CRC_INIT;
      poll_q <= 32'd0;
    end else begin
      op_q   <= op_d;
      addr_q <= addr_d;
      rem_q  <= rem_d;
      idx_q  <= idx_d;
      crc_q  <= crc_d;
      poll_q <= poll_d;
    end
  end

endmodule

FILE: rtl/sncf_out_q.sv
// ----------------------------------------------------------------------------
// sncf_out_q: result queue
// Four-entry queue that takes up to two results a cycle from the sequencer and
// hands one result a cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module sncf_out_q
  import sncf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  out_item_t  q_mem [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_item_o  = q_mem[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for the largest burst a request can produce
  assign space_o     = (cnt_q <= 3'd2);

  // Advance pointers and fill level
  always_comb begin
    wr_d  = wr_q + push_i.num;
    rd_d  = rd_q + {1'b0, pop};
    cnt_d = cnt_q + {1'b0, push_i.num} - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      q_mem[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      q_mem[wr_q + 2'd1] <= push_i.r1;
    end
  end

endmodule

FILE: rtl/spi_nor_flash_command_engine_unit.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_engine_unit: SPI NOR flash command engine
// Host-side sequencer for write enable, sector erase, page program, read and
// CRC-32 over read bytes, exchanging one byte with the flash per request.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+------------------------------
//   in      | request   | in_valid/in_ready   | in_item_i  (in_item_t)
//   out     | result    | out_valid/out_ready | out_item_o (out_item_t)
//   apb     | config    | psel/penable/pready | paddr/pwdata/prdata
//
// A request is taken every cycle while the two-entry front queue has room;
// its results pass through the front queue and the result queue, both registered.
// The sequencer retires one request per cycle while the result queue has two
// free slots; a read data reply yields two results, so reads are bounded by
// the single-result output port.
// Output stalls back up through the result queue and then the front queue.
// Reset is immediate: no clearing pass, the poll limit returns to 10000000.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_engine_unit
  import sncf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  logic [31:0] poll_limit_q;
  logic        req_valid;
  req_t        req;
  logic        req_pop;
  logic        out_space;
  push_t       push;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_POLL_LIMIT) ? poll_limit_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= POLL_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr == REG_POLL_LIMIT) begin
      poll_limit_q <= pwdata;
    end
  end

  sncf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  sncf_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .poll_limit_i (poll_limit_q),
    .req_valid_i  (req_valid),
    .req_i        (req),
    .req_pop_o    (req_pop),
    .out_space_i  (out_space),
    .push_o       (push)
  );

  sncf_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/sncf_checker.sv
// ----------------------------------------------------------------------------
// sncf_checker: port-level checks of the flash command engine
// Watches the result channel and the configuration port; bound to the top.
// ----------------------------------------------------------------------------
module sncf_checker
  import sncf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_item_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // A finish result always closes its request
  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_FINISH |-> out_item_o.last)
    else $error("finish result not marked last");

  // A read byte is always followed by another result of the same request
  a_host_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind == KIND_HOST |-> !out_item_o.last)
    else $error("read byte marked last");

  // Only a finish result carries status or CRC
  a_status_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.kind != KIND_FINISH |->
      !out_item_o.success && out_item_o.crc_value == 32'd0)
    else $error("status on a non-finish result");

  // Read back the poll limit just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr == REG_POLL_LIMIT ##1
      paddr == REG_POLL_LIMIT |-> prdata == $past(pwdata))
    else $error("poll limit read back mismatch");

endmodule

bind spi_nor_flash_command_engine_unit sncf_checker u_sncf_checker (.*);

FILE: bench/flash_check_pkg.sv
// ----------------------------------------------------------------------------
// flash_check_pkg: result predictor and scoreboard for the flash engine bench
// Tracks the command sequencer state, predicts the SPI bytes, host bytes and
// finish results of every accepted request, and compares the results that
// leave the block in order, field by field.
// ----------------------------------------------------------------------------
package flash_check_pkg;
  import sncf_pkg::*;

  class flash_scoreboard;
    // Sequencer state as seen from the outside
    logic [31:0] poll_limit;
    phase_e      seq_phase;
    logic [2:0]  seq_op;
    logic [23:0] bytes_left;
    logic [1:0]  addr_byte_idx;
    logic [31:0] crc_acc;
    logic [31:0] polls_done;
    logic [23:0] addr_latch;

    out_item_t   predicted_results[$];
    out_item_t   step_results[$];
    int          mismatches;
    int          results_checked;
    int          ops_finished;
    int          ops_failed;

    function new();
      poll_limit      = POLL_LIMIT_RST;
      seq_phase       = PH_IDLE;
      seq_op          = OP_WREN;
      bytes_left      = '0;
      addr_byte_idx   = '0;
      crc_acc         = CRC_INIT;
      polls_done      = '0;
      addr_latch      = '0;
      mismatches      = 0;
      results_checked = 0;
      ops_finished    = 0;
      ops_failed      = 0;
    endfunction

    function void set_poll_limit(logic [31:0] value);
      poll_limit = value;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] spi, logic rel, logic [7:0] hd,
                       logic [31:0] crc, logic ok);
      out_item_t r;
      r.kind           = kind;
      r.spi_byte       = spi;
      r.release_select = rel;
      r.host_data      = hd;
      r.crc_value      = crc;
      r.success        = ok;
      r.last           = 1'b0;
      step_results.push_back(r);
    endfunction

    function void send_byte(logic [7:0] b, logic rel);
      emit(KIND_SPI, b, rel, 8'h00, 32'h0, 1'b0);
    endfunction

    function void finish_op(logic [31:0] crc, logic ok);
      seq_phase = PH_IDLE;
      ops_finished++;
      if (!ok) ops_failed++;
      emit(KIND_FINISH, 8'h00, 1'b0, 8'h00, crc, ok);
    endfunction

    // Send one address byte, most significant first; erase and any zero-length
    // operation release chip select after the last one
    function void send_addr_byte(logic [1:0] idx);
      logic        rel;
      logic [23:0] shifted;
      rel           = (idx == 2'd2) && (seq_op == OP_ERASE || bytes_left == '0);
      addr_byte_idx = idx;
      seq_phase     = PH_ADDR_REPLY;
      shifted       = addr_latch >> (16 - 8 * int'(idx));
      send_byte(shifted[7:0], rel);
    endfunction

    function void start_poll();
      polls_done = '0;
      if (poll_limit == '0) begin
        finish_op(32'h0, 1'b0);
      end else begin
        seq_phase = PH_POLL_CMD;
        send_byte(SPI_RDSR, 1'b0);
      end
    endfunction

    function void next_data_byte();
      if (bytes_left == '0) begin
        finish_op((seq_op == OP_CRC) ? ~crc_acc : 32'h0, 1'b1);
      end else begin
        seq_phase = PH_DATA_REPLY;
        send_byte(SPI_DUMMY, bytes_left == 24'd1);
        bytes_left--;
      end
    endfunction

    // Reflected CRC-32, one byte at a time
    function void fold_crc(logic [7:0] b);
      crc_acc ^= {24'h0, b};
      for (int k = 0; k < 8; k++) begin
        crc_acc = (crc_acc >> 1) ^ (crc_acc[0] ? CRC_POLY : 32'h0);
      end
    endfunction

    function void take_reply(logic [7:0] b);
      case (seq_phase)
        PH_WE_REPLY: begin
          if (seq_op == OP_WREN) begin
            finish_op(32'h0, 1'b1);
          end else begin
            seq_phase = PH_CMD_REPLY;
            send_byte((seq_op == OP_ERASE) ? SPI_SE : SPI_PP, 1'b0);
          end
        end
        PH_CMD_REPLY: send_addr_byte(2'd0);
        PH_ADDR_REPLY: begin
          if (addr_byte_idx < 2'd2) begin
            send_addr_byte(addr_byte_idx + 2'd1);
          end else if (seq_op == OP_ERASE) begin
            start_poll();
          end else if (seq_op == OP_PROGRAM) begin
            if (bytes_left == '0) start_poll();
            else seq_phase = PH_WAIT_HOST;
          end else begin
            next_data_byte();
          end
        end
        PH_DATA_REPLY: begin
          if (seq_op == OP_PROGRAM) begin
            if (bytes_left == '0) start_poll();
            else seq_phase = PH_WAIT_HOST;
          end else begin
            if (seq_op == OP_READ) emit(KIND_HOST, 8'h00, 1'b0, b, 32'h0, 1'b0);
            else fold_crc(b);
            next_data_byte();
          end
        end
        PH_POLL_CMD: begin
          seq_phase = PH_POLL_STAT;
          send_byte(SPI_DUMMY, 1'b1);
        end
        PH_POLL_STAT: begin
          if (!b[0]) begin
            finish_op(32'h0, 1'b1);
          end else begin
            polls_done++;
            if (polls_done >= poll_limit) begin
              finish_op(32'h0, 1'b0);
            end else begin
              seq_phase = PH_POLL_CMD;
              send_byte(SPI_RDSR, 1'b0);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Predict the results of one accepted request and queue them
    function int note_request(in_item_t req);
      step_results.delete();
      case (req.opcode)
        OPC_START: begin
          if (seq_phase == PH_IDLE) begin
            if (req.operation > OP_CRC) begin
              finish_op(32'h0, 1'b0);
            end else begin
              seq_op        = req.operation;
              addr_latch    = req.flash_address;
              bytes_left    = req.transfer_length;
              addr_byte_idx = '0;
              polls_done    = '0;
              crc_acc       = CRC_INIT;
              if (req.operation <= OP_PROGRAM) begin
                seq_phase = PH_WE_REPLY;
                send_byte(SPI_WREN, 1'b1);
              end else begin
                seq_phase = PH_CMD_REPLY;
                send_byte(SPI_READ, 1'b0);
              end
            end
          end
        end
        OPC_HOST: begin
          if (seq_phase == PH_WAIT_HOST) begin
            seq_phase = PH_DATA_REPLY;
            send_byte(req.host_byte, bytes_left == 24'd1);
            bytes_left--;
          end
        end
        OPC_REPLY: take_reply(req.flash_byte);
        default: ;
      endcase
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) predicted_results.push_back(step_results[i]);
      return step_results.size();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("[%0t] ERROR: %s", $time, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                         results_checked, name, got, want));
      end
    endtask

    // Compare one accepted result with the oldest prediction
    task check_result(out_item_t got);
      out_item_t want;
      if (predicted_results.size() == 0) begin
        report($sformatf("result with nothing predicted: %p", got));
        return;
      end
      want = predicted_results.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("spi_byte", got.spi_byte, want.spi_byte);
      check_field("release_select", got.release_select, want.release_select);
      check_field("host_data", got.host_data, want.host_data);
      check_field("crc_value", got.crc_value, want.crc_value);
      check_field("success", got.success, want.success);
      check_field("last", got.last, want.last);
      results_checked++;
    endtask
  endclass

endpackage

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: bench for the SPI NOR flash command engine
// Plays host and flash at once: drives well-formed operation sequences with
// random content and stray requests, answers status polls with planned busy
// counts, stalls both channels in bursts and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sncf_pkg::*;
  import flash_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OPC_UNUSED    = 2'd3;
  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         HOLD_CYCLES   = 400;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;

  flash_scoreboard sb;
  int gap_pct        = 0;
  int stall_pct      = 0;
  int hold_left      = 0;
  bit long_hold_req  = 1'b0;
  int useful_items   = 0;
  int accepted_items = 0;
  int cycle_count    = 0;

  spi_nor_flash_command_engine_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  // Accept results, check them, and drive ready with bursts and one long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_item_o);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HOLD_CYCLES;
        out_ready_i   <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left  = $urandom_range(1, 16) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stop a hung run
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still due",
             cycle_count, sb.predicted_results.size());
    $display("Verification failed");
    $finish;
  end

  function automatic in_item_t random_fields();
    in_item_t req;
    req.opcode          = 2'($urandom);
    req.operation       = 3'($urandom);
    req.flash_address   = 24'($urandom);
    req.transfer_length = 24'($urandom);
    req.host_byte       = 8'($urandom);
    req.flash_byte      = 8'($urandom);
    return req;
  endfunction

  // Build a request that the sequencer drops in its present phase
  function automatic in_item_t stray_request();
    in_item_t req;
    req = random_fields();
    case ($urandom_range(0, 2))
      0: req.opcode = OPC_UNUSED;
      1: req.opcode = (sb.seq_phase != PH_IDLE) ? OPC_START : OPC_HOST;
      default: req.opcode = (sb.seq_phase == PH_WAIT_HOST) ? OPC_REPLY : OPC_HOST;
    endcase
    return req;
  endfunction

  // Hold a request on the input until it is taken, then predict its results
  task automatic offer(in_item_t req);
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    void'(sb.note_request(req));
    accepted_items++;
  endtask

  // Drop valid for a random burst, except while the output is held off
  task automatic maybe_gap();
    if (hold_left == 0 && !long_hold_req && gap_pct > 0 &&
        $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Wait until every predicted result has left the block
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.predicted_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_poll_limit(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_POLL_LIMIT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_poll_limit(value);
  endtask

  // Run one operation to its finish, answering as host and flash; status
  // reads report busy for the first busy_polls polls
  task automatic run_operation(logic [2:0] op, logic [23:0] addr, logic [23:0] len,
                               int busy_polls, int stray_pct);
    in_item_t req;
    int       stat_seen;
    req                 = random_fields();
    req.opcode          = OPC_START;
    req.operation       = op;
    req.flash_address   = addr;
    req.transfer_length = len;
    maybe_gap();
    offer(req);
    useful_items++;
    stat_seen = 0;
    while (sb.seq_phase != PH_IDLE) begin
      maybe_gap();
      if (stray_pct > 0 && $urandom_range(0, 99) < stray_pct) begin
        offer(stray_request());
      end else begin
        req = random_fields();
        if (sb.seq_phase == PH_WAIT_HOST) begin
          req.opcode = OPC_HOST;
        end else begin
          req.opcode = OPC_REPLY;
          if (sb.seq_phase == PH_POLL_STAT) begin
            req.flash_byte[0] = (stat_seen < busy_polls);
            stat_seen++;
          end
        end
        offer(req);
        useful_items++;
      end
    end
  endtask

  // Pick an operation; lengths are mostly short, a few longer
  task automatic random_operation(int stray_pct);
    int          pick;
    logic [2:0]  op;
    logic [23:0] len;
    int          busy;
    pick = $urandom_range(0, 99);
    if (pick < 5) op = OP_WREN;
    else if (pick < 20) op = OP_ERASE;
    else if (pick < 50) op = OP_PROGRAM;
    else if (pick < 73) op = OP_READ;
    else if (pick < 95) op = OP_CRC;
    else op = OP_CRC + 3'($urandom_range(1, 3));
    pick = $urandom_range(0, 99);
    if (pick < 80) len = 24'($urandom_range(0, 6));
    else if (pick < 96) len = 24'($urandom_range(7, 24));
    else len = 24'($urandom_range(25, 64));
    // length has no effect on these, so use the whole field
    if (op == OP_WREN || op == OP_ERASE || op > OP_CRC) len = 24'($urandom);
    busy = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 5);
    run_operation(op, 24'($urandom), len, busy, stray_pct);
  endtask

  task automatic run_phase(logic [31:0] limit, int gap, int stall, int quota, bit hold);
    int target;
    drain();
    write_poll_limit(limit);
    gap_pct   = gap;
    stall_pct = stall;
    if (hold) long_hold_req = 1'b1;
    target = useful_items + quota;
    while (useful_items < target) random_operation(6);
  endtask

  initial begin : main_seq
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each operation at least once, unknown operation, field extremes
    run_operation(OP_WREN, 24'h000000, 24'h000000, 0, 0);
    run_operation(OP_CRC + 3'd3, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
    run_operation(OP_ERASE, 24'hFFFFFF, 24'hFFFFFF, 0, 0);
    run_operation(OP_READ, 24'h000000, 24'h000000, 0, 0);
    run_operation(OP_CRC, 24'hA5C3F0, 24'h000000, 0, 0);
    run_operation(OP_CRC, 24'h0F3C5A, 24'h000001, 0, 0);
    // Zero poll limit: program finishes right after its command frame
    drain();
    write_poll_limit(32'h0);
    run_operation(OP_PROGRAM, 24'h123456, 24'h000000, 0, 0);

    // Random phases across poll limits and idling levels
    run_phase(32'hFFFF_FFFF, 25, 25, 65, 1'b0);
    run_phase(32'd1, 10, 30, 65, 1'b1);
    run_phase(32'd3, 35, 10, 55, 1'b0);
    run_phase(POLL_LIMIT_RST, 0, 0, 50, 1'b0);
    drain();

    $display("Run summary: %0d requests accepted (%0d in operation sequences),",
             accepted_items, useful_items);
    $display("  %0d results checked, %0d operations finished, %0d with success low",
             sb.results_checked, sb.ops_finished, sb.ops_failed);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
